@@ src/tet_pkg.sv @@
// Shared types and constants of the timed event table.
// No dependencies; imported by tet_ctrl, tet_dpath, the top level and the testbench.
package tet_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] MODE_SCHED   = 2'd0;
  localparam logic [1:0] MODE_COLLECT = 2'd1;
  localparam logic [1:0] MODE_FIRE    = 2'd2;

  localparam logic [1:0] KIND_SCHED = 2'd0;
  localparam logic [1:0] KIND_FULL  = 2'd1;
  localparam logic [1:0] KIND_EVENT = 2'd2;
  localparam logic [1:0] KIND_NONE  = 2'd3;

  localparam logic REG_RUNNING = 1'b0;

  typedef struct packed {
    logic [1:0]  mode;
    logic [47:0] frame;
    logic [47:0] end_frame;
    logic [7:0]  status_byte;
    logic [7:0]  first_data;
    logic [7:0]  second_data;
    logic [6:0]  capacity;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [47:0] target_frame;
    logic [31:0] seq_order;
    logic [7:0]  out_status;
    logic [7:0]  out_first;
    logic [7:0]  out_second;
    logic [47:0] stamp;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [47:0] frame;
    logic [31:0] order;
    logic [7:0]  status;
    logic [7:0]  first;
    logic [7:0]  second;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       idx_clr;
    logic       idx_inc;
    logic       sched_wr;
    logic       mark;
    logic       pass_clr;
    logic       take;
    logic       unmark;
    logic       emit;
    logic [1:0] emit_kind;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] mode;
    logic       go_ok;
    logic       slot_valid;
    logic       slot_marked;
    logic       idx_last;
    logic       cap_hit;
    logic       due;
    logic       better;
    logic       count_zero;
    logic       last_one;
  } sts_t;

endpackage

@@ src/tet_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/tet_ctrl.sv @@
// Controller state machine of the timed event table.
// Depends on tet_pkg; drives tet_dpath through cmd_t and reads sts_t.
module tet_ctrl import tet_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DISP = 4'd1;
  localparam logic [3:0] ST_FREE = 4'd2;
  localparam logic [3:0] ST_MRD  = 4'd3;
  localparam logic [3:0] ST_MEV  = 4'd4;
  localparam logic [3:0] ST_MEND = 4'd5;
  localparam logic [3:0] ST_PRD  = 4'd6;
  localparam logic [3:0] ST_PEV  = 4'd7;
  localparam logic [3:0] ST_EMIT = 4'd8;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.idx_clr = 1'b1;
          state_nxt   = ST_DISP;
        end
      end
      ST_DISP: begin
        priority if (sts.mode == MODE_SCHED) begin
          state_nxt = ST_FREE;
        end else if (sts.mode == MODE_COLLECT || sts.mode == MODE_FIRE) begin
          if (sts.go_ok) begin
            state_nxt = ST_MRD;
          end else begin
            cmd.emit      = 1'b1;
            cmd.emit_kind = KIND_NONE;
            state_nxt     = ST_IDLE;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FREE: begin
        priority if (!sts.slot_valid) begin
          cmd.sched_wr  = 1'b1;
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_SCHED;
          state_nxt     = ST_IDLE;
        end else if (sts.idx_last) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_FULL;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_MRD: begin
        priority if (sts.cap_hit) begin
          state_nxt = ST_MEND;
        end else if (sts.slot_valid) begin
          state_nxt = ST_MEV;
        end else if (sts.idx_last) begin
          state_nxt = ST_MEND;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_MEV: begin
        cmd.mark = sts.due;
        if (sts.idx_last) begin
          state_nxt = ST_MEND;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_MRD;
        end
      end
      ST_MEND: begin
        if (sts.count_zero) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_NONE;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.pass_clr = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_nxt    = ST_PRD;
        end
      end
      ST_PRD: begin
        priority if (sts.slot_marked) begin
          state_nxt = ST_PEV;
        end else if (sts.idx_last) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      ST_PEV: begin
        cmd.take = sts.better;
        if (sts.idx_last) begin
          state_nxt = ST_EMIT;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = ST_PRD;
        end
      end
      ST_EMIT: begin
        cmd.emit      = 1'b1;
        cmd.emit_kind = KIND_EVENT;
        cmd.unmark    = 1'b1;
        if (sts.last_one) begin
          state_nxt = ST_IDLE;
        end else begin
          cmd.pass_clr = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_nxt    = ST_PRD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

@@ src/tet_dpath.sv @@
// Datapath of the timed event table: slot RAM, valid and mark bits,
// scan index, best-candidate register and result register.
// Depends on tet_pkg and tet_ram; commanded by tet_ctrl.
module tet_dpath import tet_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  logic      running,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      out_strobe,
  output out_item_t out_item
);

  in_item_t         item_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] count_r;
  logic [TABLE_DEPTH-1:0] valid_r;
  logic [TABLE_DEPTH-1:0] mark_r;
  logic [31:0]      next_order_r;
  logic             found_r;
  slot_t            best_r;
  logic [IDX_W-1:0] best_idx_r;
  logic             out_strobe_r;
  out_item_t        out_item_r;

  slot_t            rd_slot;
  slot_t            wr_slot;
  logic [CNT_W-1:0] cap_lim;
  logic [47:0]      cand_target;
  logic [47:0]      best_target;
  logic             is_collect;
  out_item_t        emit_item;

  assign wr_slot = '{frame: item_r.frame, order: next_order_r,
                     status: item_r.status_byte, first: item_r.first_data,
                     second: item_r.second_data};

  tet_ram #(.WIDTH(SLOT_W), .DEPTH(TABLE_DEPTH)) u_slots (
    .clk     (clk),
    .wr_en   (cmd.sched_wr),
    .wr_addr (idx_r),
    .wr_data (wr_slot),
    .rd_addr (idx_r),
    .rd_data (rd_slot)
  );

  assign is_collect = (item_r.mode == MODE_COLLECT);
  assign cap_lim = (item_r.capacity > 7'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                      : item_r.capacity[CNT_W-1:0];

  // Collect clamps the event frame up to the window begin.
  assign cand_target = (is_collect && rd_slot.frame < item_r.frame) ? item_r.frame
                                                                     : rd_slot.frame;
  assign best_target = (is_collect && best_r.frame < item_r.frame) ? item_r.frame
                                                                    : best_r.frame;

  always_comb begin
    sts.mode        = item_r.mode;
    sts.go_ok       = running && (!is_collect ||
                      (cap_lim != '0 && item_r.end_frame > item_r.frame));
    sts.slot_valid  = valid_r[idx_r];
    sts.slot_marked = mark_r[idx_r];
    sts.idx_last    = (idx_r == IDX_W'(TABLE_DEPTH - 1));
    sts.cap_hit     = is_collect && (count_r == cap_lim);
    sts.due         = is_collect ? (rd_slot.frame < item_r.end_frame)
                                 : (rd_slot.frame <= item_r.frame);
    // Collect orders by clamped frame, then order; strict compare keeps the earlier slot on ties; fire takes the first.
    sts.better      = !found_r || (is_collect &&
                      ({cand_target, rd_slot.order} < {best_target, best_r.order}));
    sts.count_zero  = (count_r == '0);
    sts.last_one    = (count_r == CNT_W'(1));
  end

  always_comb begin
    emit_item = '0;
    unique case (cmd.emit_kind)
      KIND_SCHED, KIND_FULL: begin
        emit_item.kind         = cmd.emit_kind;
        emit_item.target_frame = item_r.frame;
        emit_item.seq_order    = (cmd.emit_kind == KIND_SCHED) ? next_order_r : 32'd0;
        emit_item.out_status   = item_r.status_byte;
        emit_item.out_first    = item_r.first_data;
        emit_item.out_second   = item_r.second_data;
        emit_item.last         = 1'b1;
      end
      KIND_EVENT: begin
        emit_item.kind         = KIND_EVENT;
        emit_item.target_frame = best_target;
        emit_item.seq_order    = best_r.order;
        emit_item.out_status   = best_r.status;
        emit_item.out_first    = best_r.first;
        emit_item.out_second   = best_r.second;
        if (is_collect) begin
          emit_item.stamp = (best_r.frame == 48'd0) ? 48'd1 : best_r.frame;
        end else begin
          emit_item.stamp = item_r.frame;
        end
        emit_item.last         = (count_r == CNT_W'(1));
      end
      default: begin
        emit_item.kind = KIND_NONE;
        emit_item.last = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      count_r      <= '0;
      valid_r      <= '0;
      mark_r       <= '0;
      next_order_r <= '0;
      found_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IDX_W'(1);
      end
      if (cmd.load) begin
        count_r <= '0;
      end else if (cmd.mark) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.unmark) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.sched_wr) begin
        valid_r[idx_r] <= 1'b1;
        next_order_r   <= next_order_r + 32'd1;
      end
      if (cmd.mark) begin
        valid_r[idx_r] <= 1'b0;
        mark_r[idx_r]  <= 1'b1;
      end
      if (cmd.unmark) begin
        mark_r[best_idx_r] <= 1'b0;
      end
      if (cmd.pass_clr) begin
        found_r <= 1'b0;
      end else if (cmd.take) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.take) begin
      best_r     <= rd_slot;
      best_idx_r <= idx_r;
    end
    if (cmd.emit) begin
      out_item_r <= emit_item;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

@@ src/timed_event_table_unit.sv @@
// Top level of the timed event table: configuration port, controller and datapath.
// Depends on tet_pkg, tet_ctrl, tet_dpath (and tet_ram through tet_dpath).
//
// Usage:
//   Input channel: drive in_item and raise start; the transfer happens at the
//   clock edge where start is high and busy is low. busy stays high until the
//   item's final result is registered, which shows on out_item with busy low.
//   Result channel: each result is marked by out_strobe high for one cycle and
//   stays on out_item until the next one; out_item.last marks the final result
//   of an item. The receiver cannot stall; results leave at the block's pace.
//   Configuration: APB-style write of register running at address 0; pready
//   is always high. Write it only while busy is low.
// Operation, from the start transfer (TABLE_DEPTH slots, one RAM port):
//   schedule: a scan from slot 0 to the lowest free slot, which takes the item.
//   collect/fire: a mark pass over the slots, then for each emitted event a
//   selection pass over the marked slots. Each pass walks the slots through
//   the single slot RAM read port.
//   A stopped transport, a zero capacity or an empty window returns one
//   "nothing due" result; a scan that finds nothing due returns it after the
//   mark pass; an unused mode returns to idle with no result.
// Reset (rst_n low, synchronous): table empty, order counter zero, running 0.
module timed_event_table_unit import tet_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_item_t    in_item,
  output logic        out_strobe,
  output out_item_t   out_item,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic running_r;
  cmd_t cmd;
  sts_t sts;

  // Register write completes in the access phase; address bit 2 selects register running.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
    end else if (psel && penable && pwrite && paddr[2] == REG_RUNNING) begin
      running_r <= pwdata[0];
    end
  end

  assign pready = 1'b1;
  assign prdata = {31'd0, running_r};

  tet_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  tet_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .running    (running_r),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // An accepted item always keeps the block busy for the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after start transfer");

  // More results of the same item follow a result that is not the last.
  a_more_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_item.last |-> busy)
    else $error("block idle while results still pending");

  // Single-result kinds always close their item.
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.kind != KIND_EVENT |-> out_item.last)
    else $error("single-result kind without last");

endmodule

@@ tb/timed_event_table_unit_tb.sv @@
// Self-checking testbench of timed_event_table_unit: directed table, then random commands.
// Depends on tet_pkg and the RTL of timed_event_table_unit; holds its own table predictor.
`timescale 1ns / 1ps

module timed_event_table_unit_tb;
  import tet_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [2:0] RUNNING_ADDR = 3'(4 * int'(REG_RUNNING));
  localparam int RANDOM_ITEMS = 320;
  localparam int STALL_LIMIT = 20000;
  localparam int STOPPED_ROWS = 5;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_item_t    in_item;
  logic        out_strobe;
  out_item_t   out_item;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  timed_event_table_unit uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_strobe(out_strobe), .out_item(out_item), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow of the event table.
  logic        shadow_valid [TABLE_DEPTH];
  slot_t       shadow_slot [TABLE_DEPTH];
  logic [31:0] shadow_next_order;
  int          shadow_live;
  logic        shadow_running;

  out_item_t pending_results[$];
  int        fail_count;
  int        stall_cycles;

  typedef struct {
    in_item_t  item;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic out_item_t make_result(logic [1:0] kind, logic [47:0] target,
                                            logic [31:0] order, slot_t s,
                                            logic [47:0] stamp, logic last);
    out_item_t r;
    r.kind = kind;
    r.target_frame = target;
    r.seq_order = order;
    r.out_status = s.status;
    r.out_first = s.first;
    r.out_second = s.second;
    r.stamp = stamp;
    r.last = last;
    return r;
  endfunction

  // Work out the results of one accepted command and advance the shadow table.
  task automatic model_command(input in_item_t it, ref out_item_t res[$]);
    out_item_t picked[$];
    out_item_t tmp;
    slot_t     s;
    int        free_idx;
    int        limit;
    int        j;
    res.delete();
    s.frame = it.frame;
    s.order = 32'd0;
    s.status = it.status_byte;
    s.first = it.first_data;
    s.second = it.second_data;
    case (it.mode)
      MODE_SCHED: begin
        free_idx = -1;
        if (shadow_live < TABLE_DEPTH)
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (!shadow_valid[i] && free_idx < 0) free_idx = i;
        if (free_idx < 0) begin
          res.push_back(make_result(KIND_FULL, it.frame, 32'd0, s, 48'd0, 1'b1));
        end else begin
          s.order = shadow_next_order;
          shadow_slot[free_idx] = s;
          shadow_valid[free_idx] = 1'b1;
          shadow_next_order++;
          shadow_live++;
          res.push_back(make_result(KIND_SCHED, it.frame, s.order, s, 48'd0, 1'b1));
        end
      end
      MODE_COLLECT: begin
        limit = (it.capacity > TABLE_DEPTH) ? TABLE_DEPTH : int'(it.capacity);
        if (shadow_running && limit > 0 && it.end_frame > it.frame) begin
          for (int i = 0; i < TABLE_DEPTH && picked.size() < limit; i++) begin
            if (shadow_valid[i] && shadow_slot[i].frame < it.end_frame) begin
              picked.push_back(make_result(KIND_EVENT,
                (shadow_slot[i].frame < it.frame) ? it.frame : shadow_slot[i].frame,
                shadow_slot[i].order, shadow_slot[i],
                (shadow_slot[i].frame != 0) ? shadow_slot[i].frame : 48'd1, 1'b0));
              shadow_valid[i] = 1'b0;
              shadow_live--;
            end
          end
          // Sort by clamped frame, then by order number; stable insertion.
          for (int i = 1; i < picked.size(); i++) begin
            tmp = picked[i];
            j = i;
            while (j > 0 && (picked[j-1].target_frame > tmp.target_frame ||
                   (picked[j-1].target_frame == tmp.target_frame &&
                    picked[j-1].seq_order > tmp.seq_order))) begin
              picked[j] = picked[j-1];
              j--;
            end
            picked[j] = tmp;
          end
        end
      end
      MODE_FIRE: begin
        if (shadow_running)
          for (int i = 0; i < TABLE_DEPTH; i++)
            if (shadow_valid[i] && shadow_slot[i].frame <= it.frame) begin
              picked.push_back(make_result(KIND_EVENT, shadow_slot[i].frame,
                shadow_slot[i].order, shadow_slot[i], it.frame, 1'b0));
              shadow_valid[i] = 1'b0;
              shadow_live--;
            end
      end
      default: ;
    endcase
    if (it.mode == MODE_COLLECT || it.mode == MODE_FIRE) begin
      if (picked.size() == 0) begin
        tmp = '0;
        tmp.kind = KIND_NONE;
        tmp.last = 1'b1;
        res.push_back(tmp);
      end else begin
        picked[picked.size()-1].last = 1'b1;
        res = picked;
      end
    end
  endtask

  function automatic in_item_t make_cmd(logic [1:0] mode, logic [47:0] frame,
                                        logic [47:0] end_frame, logic [7:0] st,
                                        logic [7:0] d1, logic [7:0] d2, logic [6:0] cap);
    in_item_t it;
    it.mode = mode;
    it.frame = frame;
    it.end_frame = end_frame;
    it.status_byte = st;
    it.first_data = d1;
    it.second_data = d2;
    it.capacity = cap;
    return it;
  endfunction

  function automatic void add_row(in_item_t it, bit typed, out_item_t want);
    dir_row_t r;
    r.item = it;
    r.typed = typed;
    r.want = want;
    dir_rows.push_back(r);
  endfunction

  function automatic logic [47:0] rand_frame();
    if ($urandom_range(0, 7) == 0) return 48'({$urandom(), $urandom()});
    return 48'($urandom_range(0, 300));
  endfunction

  function automatic in_item_t rand_cmd(bit sched_only);
    in_item_t it;
    int pick;
    it.frame = rand_frame();
    it.end_frame = ($urandom_range(0, 5) == 0) ? 48'({$urandom(), $urandom()})
                                               : it.frame + 48'($urandom_range(0, 300));
    it.status_byte = 8'($urandom());
    it.first_data = 8'($urandom());
    it.second_data = 8'($urandom());
    pick = $urandom_range(0, 9);
    it.capacity = (pick == 0) ? 7'd0 :
                  (pick == 1) ? 7'($urandom_range(64, 127)) : 7'($urandom_range(1, 10));
    pick = $urandom_range(0, 99);
    if (sched_only || pick < 55) it.mode = MODE_SCHED;
    else if (pick < 77) it.mode = MODE_COLLECT;
    else if (pick < 95) it.mode = MODE_FIRE;
    else it.mode = MODE_UNUSED;
    return it;
  endfunction

  // Drive one command at the falling edge and hold it until the transfer.
  task automatic send_cmd(in_item_t it, bit typed, out_item_t want, bit no_gaps);
    out_item_t res[$];
    int gap;
    gap = (!no_gaps && $urandom_range(0, 99) < 13) ? $urandom_range(1, 5) : 0;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    model_command(it, res);
    if (typed) res = '{want};
    foreach (res[k]) pending_results.push_back(res[k]);
  endtask

  // Drop start and let the block drain before touching the register.
  task automatic wait_idle(int settle);
    @(negedge clk);
    start <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0 || busy);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_running(logic value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= RUNNING_ADDR;
    pwdata <= {31'($urandom()), value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_running = value;
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[0] !== value) begin
      $display("%0t: running readback expected %0d actual %0d", $realtime, value, prdata[0]);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h actual %0h", $realtime, name, want, got);
      fail_count++;
    end
  endtask

  // Compare every strobed result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %h", $realtime, out_item);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", 64'(want.kind), 64'(out_item.kind));
        check_field("target_frame", 64'(want.target_frame), 64'(out_item.target_frame));
        check_field("seq_order", 64'(want.seq_order), 64'(out_item.seq_order));
        check_field("out_status", 64'(want.out_status), 64'(out_item.out_status));
        check_field("out_first", 64'(want.out_first), 64'(out_item.out_first));
        check_field("out_second", 64'(want.out_second), 64'(out_item.out_second));
        check_field("stamp", 64'(want.stamp), 64'(out_item.stamp));
        check_field("last", 64'(want.last), 64'(out_item.last));
      end
    end
  end

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("** timed_event_table_unit: FAILED **");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    out_item_t typed_res;
    in_item_t  it;
    fail_count = 0;
    stall_cycles = 0;
    shadow_next_order = '0;
    shadow_live = 0;
    shadow_running = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_slot[i] = '0;
    end
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    // Transport stopped: nothing due, schedule at both frame extremes, unused mode.
    typed_res = '0;
    typed_res.kind = KIND_NONE;
    typed_res.last = 1'b1;
    add_row(make_cmd(MODE_COLLECT, 48'd10, 48'd20, 8'h00, 8'h00, 8'h00, 7'd5), 1, typed_res);
    add_row(make_cmd(MODE_FIRE, '1, '1, 8'hff, 8'hff, 8'hff, 7'd127), 1, typed_res);
    add_row(make_cmd(MODE_SCHED, 48'd0, 48'd0, 8'h00, 8'h00, 8'h00, 7'd0), 0, typed_res);
    add_row(make_cmd(MODE_SCHED, '1, '1, 8'hff, 8'hff, 8'hff, 7'd127), 0, typed_res);
    add_row(make_cmd(MODE_UNUSED, 48'd1, 48'd2, 8'h12, 8'h34, 8'h56, 7'd3), 0, typed_res);
    // Transport running: zero capacity, empty window, then real picks.
    add_row(make_cmd(MODE_COLLECT, 48'd0, 48'd100, 8'h00, 8'h00, 8'h00, 7'd0), 1, typed_res);
    add_row(make_cmd(MODE_COLLECT, 48'd50, 48'd50, 8'h00, 8'h00, 8'h00, 7'd9), 1, typed_res);
    add_row(make_cmd(MODE_SCHED, 48'd5, 48'd0, 8'h90, 8'h3c, 8'h7f, 7'd0), 0, typed_res);
    add_row(make_cmd(MODE_SCHED, 48'd3, 48'd0, 8'h80, 8'h3c, 8'h00, 7'd0), 0, typed_res);
    add_row(make_cmd(MODE_SCHED, 48'd100, 48'd0, 8'hb0, 8'h07, 8'h40, 7'd0), 0, typed_res);
    add_row(make_cmd(MODE_SCHED, 48'd4, 48'd0, 8'h91, 8'h40, 8'h20, 7'd0), 0, typed_res);
    add_row(make_cmd(MODE_COLLECT, 48'd4, 48'd50, 8'h00, 8'h00, 8'h00, 7'd127), 0, typed_res);
    add_row(make_cmd(MODE_SCHED, 48'd7, 48'd0, 8'h01, 8'h02, 8'h03, 7'd0), 0, typed_res);
    add_row(make_cmd(MODE_COLLECT, 48'd0, '1, 8'h00, 8'h00, 8'h00, 7'd1), 0, typed_res);
    add_row(make_cmd(MODE_FIRE, 48'd99, 48'd0, 8'h00, 8'h00, 8'h00, 7'd0), 0, typed_res);
    add_row(make_cmd(MODE_FIRE, '1, 48'd0, 8'h00, 8'h00, 8'h00, 7'd0), 0, typed_res);
    add_row(make_cmd(MODE_FIRE, '1, 48'd0, 8'h00, 8'h00, 8'h00, 7'd0), 1, typed_res);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (i == STOPPED_ROWS) begin
        wait_idle(10);
        write_running(1'b1);
      end
      send_cmd(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want, 1'b0);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Stop and restart the transport once along the way.
      if (n == 200 || n == 240) begin
        wait_idle(10);
        write_running(n == 240);
      end
      // Fill the table past full, then drain it with one wide collect.
      if (n == 100 || n == 280) begin
        for (int k = 0; k < TABLE_DEPTH + 2; k++)
          send_cmd(rand_cmd(1'b1), 1'b0, typed_res, 1'b0);
        it = rand_cmd(1'b0);
        it.mode = MODE_COLLECT;
        it.frame = 48'd0;
        it.end_frame = '1;
        it.capacity = 7'(TABLE_DEPTH);
        send_cmd(it, 1'b0, typed_res, 1'b0);
      end
      send_cmd(rand_cmd(1'b0), 1'b0, typed_res, n >= 150 && n < 300);
    end

    wait_idle(200);
    if (fail_count == 0) begin
      $display("** timed_event_table_unit: PASSED **");
    end else begin
      $display("** timed_event_table_unit: FAILED **");
    end
    $finish;
  end

endmodule

@@ timed_event_table_unit.f @@
src/tet_pkg.sv
src/tet_ram.sv
src/tet_ctrl.sv
src/tet_dpath.sv
src/timed_event_table_unit.sv
tb/timed_event_table_unit_tb.sv
